>>> sv/afs_pkg.sv
// shared types and constants of the animation frame sampler
// no dependencies; imported by every module of the block
package afs_pkg;

  localparam int TIME_W    = 32;
  localparam int FRAME_W   = 12;
  localparam int BLEND_W   = 17;
  localparam int TW_W      = 13;
  localparam int DVD_W     = 49;
  localparam int DVS_W     = 46;
  localparam int DCNT_W    = 6;
  localparam int ADDR_W    = 4;
  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

  localparam logic [1:0] REG_CLIP_START = 2'd0;
  localparam logic [1:0] REG_CLIP_END   = 2'd1;
  localparam logic [1:0] REG_LOOPING    = 2'd2;
  localparam logic [1:0] REG_TEX_WIDTH  = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [6:0]        actor;
    logic [TIME_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  play_time;
    logic [FRAME_W-1:0] frame_now;
    logic [FRAME_W-1:0] frame_next;
    logic [BLEND_W-1:0] blend;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] clip_start;
    logic [TIME_W-1:0] clip_end;
    logic              looping;
    logic [TW_W-1:0]   texture_width;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LATCH,
    OP_SET_NOW,
    OP_SET_AHEAD,
    OP_WRAP_NOW,
    OP_WRAP_AHEAD,
    OP_MUL_NOW,
    OP_MUL_AHEAD,
    OP_FRAME_NOW,
    OP_FRAME_AHEAD,
    OP_DEN,
    OP_BLEND,
    OP_ONE,
    OP_ZERO,
    OP_STORE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic div_go;
  } cmd_t;

  typedef struct packed {
    logic d_pos;
    logic looping;
    logic clr_last;
    logic div_done;
    logic frames_eq;
  } status_t;

endpackage

>>> sv/animation_frame_sampler.sv
// top level of the animation frame sampler: register port and block wiring
// depends on afs_pkg, afs_ctrl and afs_dp
//
// channel   direction  handshake                 payload
// command   in         start_i while busy_o low  item_i   (mode, actor, value)
// result    out        done_o, one cycle         result_o (play_time, frames, blend)
// config    in         psel/penable/pwrite       pwdata at paddr 4*i, prdata reads
//
// after reset every entry of the play time store is cleared, with busy_o high
// a transfer runs the serial divider for five divisions of 49 bits when looping and
// for three when clamping; equal frames skip the last division
// a non-positive clip length skips the divider; busy_o falls in the cycle after done_o
// results cannot be held off, so nothing stalls once an item is taken
module animation_frame_sampler #(
  parameter int ACTORS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  afs_pkg::item_t              item_i,
  output logic                        busy_o,
  output logic                        done_o,
  output afs_pkg::result_t            result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import afs_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_start    <= 32'd0;
      cfg_q.clip_end      <= 32'd65536;
      cfg_q.looping       <= 1'b1;
      cfg_q.texture_width <= TW_W'(64);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_CLIP_START: cfg_q.clip_start    <= pwdata;
        REG_CLIP_END:   cfg_q.clip_end      <= pwdata;
        REG_LOOPING:    cfg_q.looping       <= pwdata[0];
        REG_TEX_WIDTH:  cfg_q.texture_width <= pwdata[TW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CLIP_START: prdata = cfg_q.clip_start;
      REG_CLIP_END:   prdata = cfg_q.clip_end;
      REG_LOOPING:    prdata = {31'd0, cfg_q.looping};
      REG_TEX_WIDTH:  prdata = {{(32-TW_W){1'b0}}, cfg_q.texture_width};
      default:        prdata = '0;
    endcase
  end

  afs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  afs_dp #(
    .ACTORS (ACTORS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

>>> sv/afs_div.sv
// restoring divider, one quotient bit per cycle
// depends on afs_pkg
module afs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [afs_pkg::DVD_W-1:0]  dividend_i,
  input  logic [afs_pkg::DVS_W-1:0]  divisor_i,
  output logic [afs_pkg::DVD_W-1:0]  quot_o,
  output logic [afs_pkg::DVS_W-1:0]  rem_o,
  output logic                       done_o
);
  import afs_pkg::*;

  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quot_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              run_q, done_q;
  logic [DVS_W:0]    trial;

  assign trial = {rem_q, quot_q[DVD_W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DCNT_W'(DVD_W);
    end else if (run_q) begin
      cnt_q  <= cnt_q - 1'b1;
      run_q  <= (cnt_q != DCNT_W'(1));
      done_q <= (cnt_q == DCNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      if (!trial[DVS_W]) begin
        rem_q  <= trial[DVS_W-1:0];
        quot_q <= {quot_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[DVS_W-2:0], quot_q[DVD_W-1]};
        quot_q <= {quot_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> sv/afs_dp.sv
// datapath: play time memory, time wrap and clamp, frame and blend arithmetic
// depends on afs_pkg and afs_div
module afs_dp #(
  parameter int ACTORS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afs_pkg::cfg_t     cfg_i,
  input  afs_pkg::item_t    item_i,
  input  afs_pkg::cmd_t     cmd_i,
  output afs_pkg::status_t  status_o,
  output afs_pkg::result_t  result_o
);
  import afs_pkg::*;

  localparam int AW = (ACTORS > 1) ? $clog2(ACTORS) : 1;

  logic [TIME_W-1:0]  mem [ACTORS];
  logic [AW-1:0]      mod_tab [128];
  logic [AW-1:0]      idx_q, clr_q, wa;
  logic               mode_q, neg_q, we;
  logic [TIME_W-1:0]  val_q, rd_q, now_q, ahead_q, wd;
  logic [TIME_W-1:0]  start_v, end_v, clamp_v, wrap_v, wrap_base, wrap_off;
  logic [FRAME_W-1:0] f0_q, f1_q, s;
  logic [BLEND_W-1:0] blend_q;
  logic [32:0]        d, num_q, off_n, off_a, off;
  logic [33:0]        x_now, x_ahead, x, absx;
  logic [44:0]        prod, den;
  logic [12:0]        df;
  logic [DVD_W-1:0]   div_a, quot;
  logic [DVS_W-1:0]   div_b, rem;
  logic               div_done;

  for (genvar g = 0; g < 128; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % ACTORS);
  end

  assign start_v = cfg_i.clip_start;
  assign end_v   = cfg_i.clip_end;
  assign d = {end_v[31], end_v} - {start_v[31], start_v};

  always_comb begin
    if (cfg_i.texture_width < TW_W'(2)) begin
      s = '0;
    end else if (cfg_i.texture_width > TW_W'(4096)) begin
      s = '1;
    end else begin
      s = FRAME_W'(cfg_i.texture_width - TW_W'(1));
    end
  end

  // offsets from the clip start, 34 bit signed
  assign x_now = (mode_q ? ({{2{rd_q[31]}}, rd_q} + {{2{val_q[31]}}, val_q})
                         : {{2{val_q[31]}}, val_q}) - {{2{start_v[31]}}, start_v};
  assign x_ahead = {{2{now_q[31]}}, now_q}
                 + (mode_q ? {{2{val_q[31]}}, val_q} : 34'd0)
                 - {{2{start_v[31]}}, start_v};
  assign x    = (cmd_i.op == OP_SET_AHEAD) ? x_ahead : x_now;
  assign absx = x[33] ? 34'(-x) : x;

  always_comb begin
    if (x[33]) begin
      clamp_v = start_v;
    end else if (x > {1'b0, d}) begin
      clamp_v = end_v;
    end else begin
      clamp_v = start_v + x[31:0];
    end
  end

  assign wrap_base = (neg_q && (rem[32:0] != '0)) ? end_v : start_v;
  assign wrap_off  = neg_q ? 32'(-rem[31:0]) : rem[31:0];
  assign wrap_v    = wrap_base + wrap_off;

  assign off_n = {now_q[31], now_q} - {start_v[31], start_v};
  assign off_a = {ahead_q[31], ahead_q} - {start_v[31], start_v};
  assign off   = (cmd_i.op == OP_MUL_AHEAD) ? off_a : off_n;
  assign prod  = 45'(off) * 45'(s);

  assign df  = (f1_q > f0_q) ? ({1'b0, f1_q} - {1'b0, f0_q})
                             : ({1'b0, f1_q} + {1'b0, s} - {1'b0, f0_q});
  assign den = 45'(d) * 45'(df[FRAME_W-1:0]);

  always_comb begin
    div_a = '0;
    div_b = '0;
    case (cmd_i.op)
      OP_SET_NOW, OP_SET_AHEAD: begin
        div_a = DVD_W'(absx);
        div_b = DVS_W'(d);
      end
      OP_MUL_NOW, OP_MUL_AHEAD: begin
        div_a = DVD_W'(prod);
        div_b = DVS_W'(d);
      end
      OP_DEN: begin
        div_a = {num_q, 16'd0};
        div_b = DVS_W'(den);
      end
      default: ;
    endcase
  end

  afs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == OP_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        mode_q <= item_i.mode;
        idx_q  <= mod_tab[item_i.actor];
        val_q  <= item_i.value;
      end
      OP_SET_NOW: begin
        neg_q <= x[33];
        now_q <= clamp_v;
      end
      OP_SET_AHEAD: begin
        neg_q   <= x[33];
        ahead_q <= clamp_v;
      end
      OP_WRAP_NOW:   now_q   <= wrap_v;
      OP_WRAP_AHEAD: ahead_q <= wrap_v;
      OP_FRAME_NOW: begin
        f0_q  <= quot[FRAME_W-1:0];
        num_q <= rem[32:0];
      end
      OP_FRAME_AHEAD: f1_q <= quot[FRAME_W-1:0];
      OP_BLEND: blend_q <= (quot > DVD_W'(BLEND_ONE)) ? BLEND_ONE : quot[BLEND_W-1:0];
      OP_ONE:   blend_q <= BLEND_ONE;
      OP_ZERO: begin
        now_q   <= '0;
        f0_q    <= '0;
        f1_q    <= '0;
        blend_q <= BLEND_ONE;
      end
      default: ;
    endcase
  end

  // play time store
  assign we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_STORE);
  assign wa = (cmd_i.op == OP_CLEAR) ? clr_q : idx_q;
  assign wd = (cmd_i.op == OP_CLEAR) ? '0 : now_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx_q];
  end

  assign status_o.d_pos     = !d[32] && (d != '0);
  assign status_o.looping   = cfg_i.looping;
  assign status_o.clr_last  = (clr_q == AW'(ACTORS - 1));
  assign status_o.div_done  = div_done;
  assign status_o.frames_eq = (f0_q == f1_q);

  assign result_o.play_time  = now_q;
  assign result_o.frame_now  = f0_q;
  assign result_o.frame_next = f1_q;
  assign result_o.blend      = blend_q;

endmodule

>>> sv/afs_ctrl.sv
// sequencing state machine of the animation frame sampler
// depends on afs_pkg
module afs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  afs_pkg::status_t  status_i,
  output afs_pkg::cmd_t     cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import afs_pkg::*;

  typedef enum logic [20:0] {
    S_CLEAR  = 21'h000001,
    S_IDLE   = 21'h000002,
    S_READ   = 21'h000004,
    S_SETN   = 21'h000008,
    S_WAITN  = 21'h000010,
    S_WRAPN  = 21'h000020,
    S_SETA   = 21'h000040,
    S_WAITA  = 21'h000080,
    S_WRAPA  = 21'h000100,
    S_MULN   = 21'h000200,
    S_WAITF0 = 21'h000400,
    S_FRN    = 21'h000800,
    S_MULA   = 21'h001000,
    S_WAITF1 = 21'h002000,
    S_FRA    = 21'h004000,
    S_DEN    = 21'h008000,
    S_WAITB  = 21'h010000,
    S_BL     = 21'h020000,
    S_ONE    = 21'h040000,
    S_ZERO   = 21'h080000,
    S_DONE   = 21'h100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_IDLE;
    cmd_o.div_go = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_READ;
        end
      end
      S_READ: state_d = status_i.d_pos ? S_SETN : S_ZERO;
      S_SETN: begin
        cmd_o.op     = OP_SET_NOW;
        cmd_o.div_go = status_i.looping;
        state_d      = status_i.looping ? S_WAITN : S_SETA;
      end
      S_WAITN: if (status_i.div_done) state_d = S_WRAPN;
      S_WRAPN: begin
        cmd_o.op = OP_WRAP_NOW;
        state_d  = S_SETA;
      end
      S_SETA: begin
        cmd_o.op     = OP_SET_AHEAD;
        cmd_o.div_go = status_i.looping;
        state_d      = status_i.looping ? S_WAITA : S_MULN;
      end
      S_WAITA: if (status_i.div_done) state_d = S_WRAPA;
      S_WRAPA: begin
        cmd_o.op = OP_WRAP_AHEAD;
        state_d  = S_MULN;
      end
      S_MULN: begin
        cmd_o.op     = OP_MUL_NOW;
        cmd_o.div_go = 1'b1;
        state_d      = S_WAITF0;
      end
      S_WAITF0: if (status_i.div_done) state_d = S_FRN;
      S_FRN: begin
        cmd_o.op = OP_FRAME_NOW;
        state_d  = S_MULA;
      end
      S_MULA: begin
        cmd_o.op     = OP_MUL_AHEAD;
        cmd_o.div_go = 1'b1;
        state_d      = S_WAITF1;
      end
      S_WAITF1: if (status_i.div_done) state_d = S_FRA;
      S_FRA: begin
        cmd_o.op = OP_FRAME_AHEAD;
        state_d  = S_DEN;
      end
      S_DEN: begin
        cmd_o.op     = OP_DEN;
        cmd_o.div_go = !status_i.frames_eq;
        state_d      = status_i.frames_eq ? S_ONE : S_WAITB;
      end
      S_WAITB: if (status_i.div_done) state_d = S_BL;
      S_BL: begin
        cmd_o.op = OP_BLEND;
        state_d  = S_DONE;
      end
      S_ONE: begin
        cmd_o.op = OP_ONE;
        state_d  = S_DONE;
      end
      S_ZERO: begin
        cmd_o.op = OP_ZERO;
        state_d  = S_DONE;
      end
      S_DONE: begin
        cmd_o.op = OP_STORE;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> sv/afs_checker.sv
// port level checks of the animation frame sampler, bound to the top level
// depends on afs_pkg and animation_frame_sampler
module afs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input afs_pkg::result_t  result_o
);
  import afs_pkg::*;

  // a result only ever appears while an item is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  // an accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  // one result per item, never two in a row
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");

  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.blend <= BLEND_ONE)) else $error("blend above one");

  a_equal_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.frame_now == result_o.frame_next))
      |-> (result_o.blend == BLEND_ONE)) else $error("equal frames without full blend");

endmodule

bind animation_frame_sampler afs_checker u_afs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

>>> bench/tb.sv
// self-checking bench for animation_frame_sampler: directed and random transfers
// on the command port, register writes over apb, results checked against a model
// depends on afs_pkg and the animation_frame_sampler rtl
`timescale 1ns / 100ps

module tb;
  import afs_pkg::*;

  localparam int ACTOR_CNT = 128;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  item_t item_i;
  logic busy_o;
  logic done_o;
  result_t result_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  animation_frame_sampler #(.ACTORS(ACTOR_CNT)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .done_o(done_o), .result_o(result_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model copy of registers and play time store
  longint clip_lo, clip_hi;
  bit     wrap_mode;
  int     tex_cols;
  longint actor_times [ACTOR_CNT];

  result_t expected_results [$];
  int      mismatches;
  int      results_seen;
  int      items_sent;
  longint  cycles;
  bit      calm;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint fold_time(longint t, longint d);
    longint r;
    if (wrap_mode) begin
      r = (t - clip_lo) % d;
      return (r >= 0) ? r + clip_lo : r + clip_hi;
    end
    if (t < clip_lo) return clip_lo;
    if (t > clip_hi) return clip_hi;
    return t;
  endfunction

  function automatic result_t sample_actor(item_t it);
    result_t res;
    longint d, val, step, now, ahead, s, f0, f1, df, num, bl;
    int idx;
    idx = int'(it.actor) % ACTOR_CNT;
    val = longint'($signed(it.value));
    d = clip_hi - clip_lo;
    res = '0;
    if (d <= 0) begin
      actor_times[idx] = 0;
      res.blend = BLEND_ONE;
      return res;
    end
    step = it.mode ? val : 0;
    now = fold_time(it.mode ? actor_times[idx] + val : val, d);
    ahead = fold_time(now + step, d);
    actor_times[idx] = now;
    s = (tex_cols < 2) ? 0 : tex_cols - 1;
    if (s > 4095) s = 4095;
    f0 = ((now - clip_lo) * s) / d;
    f1 = ((ahead - clip_lo) * s) / d;
    if (f0 == f1) begin
      bl = 65536;
    end else begin
      df = (f1 > f0) ? f1 - f0 : f1 + s - f0;
      num = (now - clip_lo) * s - d * f0;
      bl = (d * df != 0) ? (num * 65536) / (d * df) : 65536;
      if (bl > 65536) bl = 65536;
    end
    res.play_time = now[31:0];
    res.frame_now = f0[11:0];
    res.frame_next = f1[11:0];
    res.blend = bl[16:0];
    return res;
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    $display("%0t %s mismatch: expected %0d got %0d", $realtime, field, exp_v, act_v);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transfer, got play_time %0d", $realtime,
                 $signed(result_o.play_time));
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.play_time !== result_o.play_time)
          report("play_time", $signed(exp_r.play_time), $signed(result_o.play_time));
        if (exp_r.frame_now !== result_o.frame_now)
          report("frame_now", exp_r.frame_now, result_o.frame_now);
        if (exp_r.frame_next !== result_o.frame_next)
          report("frame_next", exp_r.frame_next, result_o.frame_next);
        if (exp_r.blend !== result_o.blend)
          report("blend", exp_r.blend, result_o.blend);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CLIP_START: clip_lo = longint'($signed(val));
      REG_CLIP_END:   clip_hi = longint'($signed(val));
      REG_LOOPING:    wrap_mode = val[0];
      REG_TEX_WIDTH:  tex_cols = int'(val[TW_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_clip(longint lo, longint hi, bit wrap, int cols);
    write_reg(REG_CLIP_START, lo[31:0]);
    write_reg(REG_CLIP_END, hi[31:0]);
    write_reg(REG_LOOPING, {31'd0, wrap});
    write_reg(REG_TEX_WIDTH, cols);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_item(bit mode, int actor, logic [31:0] val);
    item_t it;
    it.mode = mode;
    it.actor = actor[6:0];
    it.value = val;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 20) begin
      repeat ($urandom_range(300, 1)) @(negedge clk_i);
    end
    start_i = 1'b1;
    item_i = it;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    expected_results.push_back(sample_actor(it));
    items_sent++;
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic run_edge_items();
    send_item(0, 0, 32'd0);
    send_item(0, 127, 32'h0001_0000);
    send_item(0, 1, 32'h8000_0000);
    send_item(0, 2, 32'h7fff_ffff);
    send_item(0, 3, 32'hffff_8000);
    send_item(1, 3, 32'h0000_0400);
    send_item(1, 3, 32'hffff_fc00);
    send_item(1, 127, 32'h7fff_ffff);
    send_item(1, 127, 32'h7fff_ffff);
    send_item(1, 2, 32'h8000_0000);
    send_item(1, 0, 32'd0);
    send_item(1, 0, 32'h0000_0001);
    send_item(0, 5, 32'h0000_8000);
    send_item(1, 5, 32'h0001_0000);
  endtask

  task automatic test_looping_defaults();
    run_edge_items();
    drain();
  endtask

  task automatic test_clamping();
    set_clip(-32'sd131072, 32'sd196608, 1'b0, 4096);
    run_edge_items();
    drain();
  endtask

  task automatic test_empty_clip();
    set_clip(32'sd65536, 32'sd65536, 1'b1, 64);
    send_item(1, 7, 32'h0000_1000);
    send_item(0, 7, 32'h0001_0000);
    drain();
    set_clip(32'sh7fff_ffff, -32'sd2147483648, 1'b0, 64);
    send_item(1, 8, 32'h1234_5678);
    drain();
  endtask

  task automatic test_texture_widths();
    int widths [5] = '{0, 1, 2, 4097, 8191};
    foreach (widths[i]) begin
      set_clip(-32'sd2147483648, 32'sh7fff_ffff, i[0], widths[i]);
      send_item(0, 9, $urandom);
      send_item(1, 9, $urandom);
      send_item(1, 9, 32'h0100_0000);
      drain();
    end
  endtask

  task automatic test_random_traffic();
    longint lo, len;
    logic [31:0] v;
    int n;
    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(4))
        0: len = $urandom_range(64, 1);
        1: len = $urandom_range(1 << 20, 1);
        2: len = longint'($urandom);
        3: len = 0 - longint'($urandom_range(1000));
        default: len = 65536;
      endcase
      lo = longint'($signed($urandom));
      if (phase == 0) lo = -2147483648;
      if (phase == 0) len = 4294967295;
      if (lo + len > 2147483647) lo = 2147483647 - len;
      if (lo < -2147483648) lo = -2147483648;
      set_clip(lo, lo + len, $urandom_range(1),
               ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(64, 2));
      calm = (phase == 5);
      for (n = 0; n < 100; n++) begin
        case ($urandom_range(5))
          0: v = $urandom;
          1: v = lo[31:0] + $urandom_range(len > 0 ? 32'(len) : 1);
          2: v = $urandom_range(len > 0 ? 32'(len / 3 + 1) : 16);
          3: v = -$urandom_range(len > 0 ? 32'(len / 3 + 1) : 16);
          default: v = $urandom_range(4096) - 2048;
        endcase
        send_item(($urandom_range(3) != 0), ($urandom_range(3) == 0) ?
                  $urandom_range(127) : $urandom_range(7), v);
        if (n == 50 && phase % 4 == 1) drain();
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    clip_lo = 0;
    clip_hi = 65536;
    wrap_mode = 1'b1;
    tex_cols = 64;
    foreach (actor_times[i]) actor_times[i] = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_looping_defaults();
    test_clamping();
    test_empty_clip();
    test_texture_widths();
    test_random_traffic();

    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("sent %0d commands, checked %0d results over looping, clamping,",
             items_sent, results_seen);
    $display("empty clips and texture widths from 0 to 8191");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
